/* hdl/mfrud_pkg.sv */
package mfrud_pkg;

  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned WORD_W    = 32;

  localparam logic [WORD_W-1:0] RESET_START = 32'h0040_0000;

  // tuser selector on the input channel
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // funct codes
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MUL     = 6'h02;

  // REGIMM rt codes
  localparam logic [4:0] RT_BLTZ = 5'h00;
  localparam logic [4:0] RT_BGEZ = 5'h01;

  // low 11 bits of three-register ALU ops
  localparam logic [10:0] ALU_LOW_MIN = 11'h021;
  localparam logic [10:0] ALU_LOW_MAX = 11'h027;
  localparam logic [10:0] ALU_SLT     = 11'h02A;
  localparam logic [10:0] ALU_SLTU    = 11'h02B;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef struct packed {
    logic [WORD_W-1:0] write_mask;
    logic [WORD_W-1:0] read_mask;
    logic [WORD_W-1:0] next_address;
    logic              next_valid;
    logic [WORD_W-1:0] target_address;
    logic              target_valid;
    logic              ends_block;
    logic [WORD_W-1:0] instr_address;
  } result_t;

  function automatic logic [WORD_W-1:0] reg_bit(input logic [REG_IDX_W-1:0] r);
    return {{(WORD_W-1){1'b0}}, 1'b1} << r;
  endfunction

endpackage

/* hdl/mips_flow_and_register_use_decoder_top.sv */
// MIPS32 control-flow and register-use decoder.
//
// Input channel (in_*): one transaction per item. in_tuser = 0 loads one entry
// of the 32-entry register value table (used as jr/jalr targets); in_tuser = 1
// decodes one instruction at the current address, which then advances by 4.
// Output channel (out_*): one transaction per decoded instruction, none for
// table loads. Each result carries the instruction address, block-end flag,
// target and fall-through leaders and the read/write register masks.
// cfg_we/cfg_wdata loads the start address into the address counter; write
// it only while no items are in flight.
// Pipeline: input register, then decode logic, then output register. A decode
// result is registered into out_* as its item leaves the input register; one
// item per cycle is sustained while out_tready stays high.
// Table writes and address updates take effect as an item leaves the input
// register, so program order holds across both item kinds.
// Reset: address counter = 0x0040_0000, table all zero, both stages empty.
// When out_tready is low the output register holds its result, the input
// register fills behind it and in_tready drops only once both are occupied.
module mips_flow_and_register_use_decoder_top
  import mfrud_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [4:0] reg_index, [36:5] reg_value, [68:37] instruction_word, [71:69] zero
  input  logic [71:0]  in_tdata,
  // [0] func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] instr_address, [32] ends_block, [33] target_valid,
  // [65:34] target_address, [66] next_valid, [98:67] next_address,
  // [130:99] read_mask, [162:131] write_mask, [167:163] zero
  output logic [167:0] out_tdata,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  // input stage
  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic [REG_IDX_W-1:0] s1_idx_r;
  logic [WORD_W-1:0]    s1_val_r;
  logic [WORD_W-1:0]    s1_word_r;
  logic                 s1_adv;

  // architectural state
  logic [WORD_W-1:0]    position_r;
  logic [WORD_W-1:0]    position_nxt;
  logic [WORD_W-1:0]    table_r [NUM_REGS];

  // output stage
  logic                 out_valid_r;
  result_t              res_r;
  result_t              res_nxt;

  logic                 s1_ready;

  assign s1_ready  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s1_ready;
  assign in_tready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tuser;
      s1_idx_r  <= in_tdata[4:0];
      s1_val_r  <= in_tdata[36:5];
      s1_word_r <= in_tdata[68:37];
    end
  end

  // decode
  logic [5:0]        op;
  logic [5:0]        funct;
  logic [4:0]        rs;
  logic [4:0]        rt;
  logic [4:0]        rd;
  logic [10:0]       low11;
  logic [WORD_W-1:0] pc_plus4;
  logic [WORD_W-1:0] br_off;
  logic              cond;

  always_comb begin
    op       = s1_word_r[31:26];
    rs       = s1_word_r[25:21];
    rt       = s1_word_r[20:16];
    rd       = s1_word_r[15:11];
    funct    = s1_word_r[5:0];
    low11    = s1_word_r[10:0];
    pc_plus4 = position_r + WORD_W'(4);
    br_off   = {{14{s1_word_r[15]}}, s1_word_r[15:0], 2'b00};
    cond     = 1'b0;

    res_nxt                = '0;
    res_nxt.instr_address  = position_r;
    res_nxt.next_address   = pc_plus4;

    unique case (op) inside
      OP_BEQ, OP_BNE: begin
        cond              = 1'b1;
        res_nxt.read_mask = reg_bit(rs) | reg_bit(rt);
      end
      OP_BLEZ, OP_BGTZ: begin
        cond              = 1'b1;
        res_nxt.read_mask = reg_bit(rs);
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZ || rt == RT_BGEZ) begin
          cond              = 1'b1;
          res_nxt.read_mask = reg_bit(rs);
        end
      end
      OP_J, OP_JAL: begin
        res_nxt.ends_block     = 1'b1;
        res_nxt.target_valid   = 1'b1;
        res_nxt.target_address = {pc_plus4[31:28], s1_word_r[25:0], 2'b00};
        if (op == OP_JAL) begin
          res_nxt.next_valid = 1'b1;
          res_nxt.write_mask = reg_bit(REG_RA);
        end
      end
      OP_SPECIAL: begin
        if (funct == FN_JR || funct == FN_JALR) begin
          res_nxt.ends_block     = 1'b1;
          res_nxt.target_valid   = 1'b1;
          res_nxt.target_address = table_r[rs];
          res_nxt.read_mask      = reg_bit(rs);
          if (funct == FN_JALR) begin
            res_nxt.next_valid = 1'b1;
            res_nxt.write_mask = reg_bit(rd);
          end
        end else if (funct == FN_SYSCALL) begin
          res_nxt.ends_block = 1'b1;
          res_nxt.next_valid = 1'b1;
        end else if ((low11 >= ALU_LOW_MIN && low11 <= ALU_LOW_MAX) ||
                     low11 == ALU_SLT || low11 == ALU_SLTU) begin
          res_nxt.read_mask  = reg_bit(rs) | reg_bit(rt);
          res_nxt.write_mask = reg_bit(rd);
        end
      end
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ORI, OP_XORI,
      OP_LB, OP_LW, OP_LHU: begin
        res_nxt.read_mask  = reg_bit(rs);
        res_nxt.write_mask = reg_bit(rt);
      end
      OP_LUI: begin
        res_nxt.write_mask = reg_bit(rt);
      end
      OP_SPECIAL2: begin
        if (funct == FN_MUL) begin
          res_nxt.read_mask  = reg_bit(rs) | reg_bit(rt);
          res_nxt.write_mask = reg_bit(rd);
        end
      end
      OP_SB, OP_SW: begin
        res_nxt.read_mask = reg_bit(rs) | reg_bit(rt);
      end
      default: begin
      end
    endcase

    if (cond) begin
      res_nxt.ends_block     = 1'b1;
      res_nxt.target_valid   = 1'b1;
      res_nxt.next_valid     = 1'b1;
      res_nxt.target_address = pc_plus4 + br_off;
    end
  end

  // address counter: config load, else advance per decoded instruction
  always_comb begin
    position_nxt = position_r;
    if (cfg_we) begin
      position_nxt = cfg_wdata;
    end else if (s1_adv && s1_func_r == FUNC_DECODE) begin
      position_nxt = pc_plus4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= RESET_START;
    end else begin
      position_r <= position_nxt;
    end
  end

  // register value table; entry 0 stays zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        table_r[i] <= '0;
      end
    end else if (s1_adv && s1_func_r == FUNC_LOAD && s1_idx_r != '0) begin
      table_r[s1_idx_r] <= s1_val_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r && s1_func_r == FUNC_DECODE;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_func_r == FUNC_DECODE) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r};

  // ---------------------------------------------------------------------------
  // assertions

  // input stalls only when both stages hold data and the sink is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // a target is only reported for an instruction that ends a block
  a_target_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!res_r.target_valid || res_r.ends_block))
    else $error("target leader without block end");

  // fall-through address always follows the instruction address
  a_next_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r.next_address == res_r.instr_address + WORD_W'(4)))
    else $error("next_address mismatch");

  // address counter moves by 4 per decoded instruction leaving the input stage
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_func_r == FUNC_DECODE && !cfg_we) |=>
      (position_r == $past(position_r) + WORD_W'(4)))
    else $error("address counter did not advance");

  // entry 0 of the table reads zero
  a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    table_r[0] == '0)
    else $error("table entry 0 not zero");

endmodule

/* tb/sv/tb_mips_flow_and_register_use_decoder_top.sv */
module tb_mips_flow_and_register_use_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfrud_pkg::*;

  // A load item can still sit in the pipe when the last decode result has
  // left, so drain a little longer.
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SQUEEZE_CYCLES  = 64;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 190;
  localparam int unsigned MAX_PRINTS      = 40;

  typedef struct {
    logic        func;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] instr_word;
  } in_item_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  // Items waiting to be driven, and decode results still owed by the DUT.
  in_item_t    pending_items[$];
  result_t     expected_decodes[$];

  // Decoder shadow state: instruction address counter and jr/jalr table.
  logic [31:0] pred_position = RESET_START;
  logic [31:0] pred_regs [NUM_REGS];

  int unsigned mismatch_count = 0;
  int unsigned tx_gap_left = 0;
  int unsigned rx_hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned squeeze_req = 0;
  int unsigned squeeze_seen = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  always #4 clk = ~clk;

  mips_flow_and_register_use_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Entry 0 is hardwired to zero; loads to it are dropped.
  function automatic void load_table_entry(input logic [4:0] idx, input logic [31:0] val);
    if (idx != 5'd0) pred_regs[idx] = val;
  endfunction

  // Decode one word at the current address, then step the address by 4.
  function automatic result_t decode_instruction(input logic [31:0] w);
    result_t     r;
    logic [5:0]  op;
    logic [5:0]  funct;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] offs;
    logic        branch;
    op     = w[31:26];
    rs     = w[25:21];
    rt     = w[20:16];
    rd     = w[15:11];
    funct  = w[5:0];
    offs   = {{14{w[15]}}, w[15:0], 2'b00};
    branch = 1'b0;
    r = '0;
    r.instr_address = pred_position;
    r.next_address  = pred_position + 32'd4;
    case (op)
      OP_BEQ, OP_BNE: begin
        branch = 1'b1;
        r.read_mask = (32'd1 << rs) | (32'd1 << rt);
      end
      OP_BLEZ, OP_BGTZ: begin
        branch = 1'b1;
        r.read_mask = 32'd1 << rs;
      end
      OP_REGIMM: begin
        // only bltz/bgez count; other rt codes decode to nothing
        if (rt == RT_BLTZ || rt == RT_BGEZ) begin
          branch = 1'b1;
          r.read_mask = 32'd1 << rs;
        end
      end
      OP_J, OP_JAL: begin
        r.ends_block     = 1'b1;
        r.target_valid   = 1'b1;
        r.target_address = {r.next_address[31:28], w[25:0], 2'b00};
        if (op == OP_JAL) begin
          r.next_valid = 1'b1;
          r.write_mask = 32'd1 << REG_RA;
        end
      end
      OP_SPECIAL: begin
        if (funct == FN_JR || funct == FN_JALR) begin
          r.ends_block     = 1'b1;
          r.target_valid   = 1'b1;
          r.target_address = pred_regs[rs];
          r.read_mask      = 32'd1 << rs;
          if (funct == FN_JALR) begin
            r.next_valid = 1'b1;
            r.write_mask = 32'd1 << rd;
          end
        end else if (funct == FN_SYSCALL) begin
          r.ends_block = 1'b1;
          r.next_valid = 1'b1;
        end else if ((w[10:0] >= ALU_LOW_MIN && w[10:0] <= ALU_LOW_MAX) ||
                     w[10:0] == ALU_SLT || w[10:0] == ALU_SLTU) begin
          r.read_mask  = (32'd1 << rs) | (32'd1 << rt);
          r.write_mask = 32'd1 << rd;
        end
      end
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ORI, OP_XORI,
      OP_LB, OP_LW, OP_LHU: begin
        r.read_mask  = 32'd1 << rs;
        r.write_mask = 32'd1 << rt;
      end
      OP_LUI: r.write_mask = 32'd1 << rt;
      OP_SPECIAL2: begin
        if (funct == FN_MUL) begin
          r.read_mask  = (32'd1 << rs) | (32'd1 << rt);
          r.write_mask = 32'd1 << rd;
        end
      end
      OP_SB, OP_SW: r.read_mask = (32'd1 << rs) | (32'd1 << rt);
      default: ;
    endcase
    if (branch) begin
      r.ends_block     = 1'b1;
      r.target_valid   = 1'b1;
      r.next_valid     = 1'b1;
      r.target_address = r.next_address + offs;
    end
    pred_position = r.next_address;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [10:0] low);
    return {OP_SPECIAL, rs, rt, rd, low};
  endfunction

  task automatic push_load(input logic [4:0] idx, input logic [31:0] val);
    pending_items.push_back('{FUNC_LOAD, idx, val, 32'd0});
  endtask

  task automatic push_decode(input logic [31:0] w);
    pending_items.push_back('{FUNC_DECODE, 5'd0, 32'd0, w});
  endtask

  // Mostly well-formed encodings with random register fields; a few raw words.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int unsigned v;
    w = $urandom;
    case ($urandom_range(0, 23))
      0, 1, 2: begin
        w[31:26] = OP_SPECIAL;
        v = $urandom_range(0, 8);
        case ($urandom_range(0, 5))
          0: w[5:0] = FN_JR;
          1: w[5:0] = FN_JALR;
          2: w[5:0] = FN_SYSCALL;
          3, 4: begin
            w[10:0] = (v < 7) ? ALU_LOW_MIN + 11'(v) : ((v == 7) ? ALU_SLT : ALU_SLTU);
            // nonzero shamt now and then: no longer an ALU op
            if ($urandom_range(0, 7) == 0) w[10:6] = 5'($urandom_range(1, 31));
          end
          default: ;
        endcase
      end
      3: begin
        w[31:26] = OP_REGIMM;
        w[20:16] = ($urandom_range(0, 3) == 0) ? 5'($urandom) :
                   (($urandom_range(0, 1) == 0) ? RT_BLTZ : RT_BGEZ);
      end
      4:  w[31:26] = OP_J;
      5:  w[31:26] = OP_JAL;
      6:  w[31:26] = OP_BEQ;
      7:  w[31:26] = OP_BNE;
      8:  w[31:26] = OP_BLEZ;
      9:  w[31:26] = OP_BGTZ;
      10: w[31:26] = OP_ADDI;
      11: w[31:26] = OP_ADDIU;
      12: w[31:26] = OP_SLTI;
      13: w[31:26] = OP_SLTIU;
      14: w[31:26] = OP_ORI;
      15: w[31:26] = OP_XORI;
      16: w[31:26] = OP_LUI;
      17: begin
        w[31:26] = OP_SPECIAL2;
        if ($urandom_range(0, 3) != 0) w[5:0] = FN_MUL;
      end
      18: w[31:26] = OP_LB;
      19: w[31:26] = OP_LW;
      20: w[31:26] = OP_LHU;
      21: w[31:26] = OP_SB;
      22: w[31:26] = OP_SW;
      default: ;
    endcase
    // pull offsets to their extremes once in a while
    if ($urandom_range(0, 7) == 0)
      w[15:0] = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
    return w;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.func       = ($urandom_range(0, 3) == 0) ? FUNC_LOAD : FUNC_DECODE;
    it.reg_index  = 5'($urandom);
    it.reg_value  = $urandom;
    it.instr_word = (it.func == FUNC_DECODE) ? random_instr() : $urandom;
    if ($urandom_range(0, 15) == 0)
      it.reg_value = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] phase_start(input int unsigned p);
    case (p)
      0: return 32'hFFFF_FFF0;   // counter wraps within a few items
      1: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      5: return RESET_START;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want, input logic [31:0] pc);
    if (got !== want)
      report_mismatch($sformatf("pc %h %s got %h want %h", pc, name, got, want));
  endtask

  task automatic check_result(input logic [167:0] d);
    result_t got;
    result_t want;
    got = result_t'(d[162:0]);
    if (expected_decodes.size() == 0) begin
      report_mismatch($sformatf("result for pc %h with no decode outstanding",
                                got.instr_address));
    end else begin
      want = expected_decodes.pop_front();
      cmp_field("instr_address",  got.instr_address,  want.instr_address,  want.instr_address);
      cmp_field("ends_block",     32'(got.ends_block), 32'(want.ends_block),
                want.instr_address);
      cmp_field("target_valid",   32'(got.target_valid), 32'(want.target_valid),
                want.instr_address);
      cmp_field("target_address", got.target_address, want.target_address, want.instr_address);
      cmp_field("next_valid",     32'(got.next_valid), 32'(want.next_valid),
                want.instr_address);
      cmp_field("next_address",   got.next_address,   want.next_address,   want.instr_address);
      cmp_field("read_mask",      got.read_mask,      want.read_mask,      want.instr_address);
      cmp_field("write_mask",     got.write_mask,     want.write_mask,     want.instr_address);
      cmp_field("tdata pad",      32'(d[167:163]),    32'd0,               want.instr_address);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the head of pending_items; tvalid stays up until the
  // transaction completes, then an optional gap before the next one.
  // The prediction runs at the accepting edge so it sees items in order.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        it = pending_items.pop_front();
        if (it.func == FUNC_LOAD) load_table_entry(it.reg_index, it.reg_value);
        else expected_decodes.push_back(decode_instruction(it.instr_word));
      end
      if (in_tvalid && !in_tready) begin
        // hold the current offer
      end else if (tx_gap_left != 0) begin
        tx_gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items[0];
        in_tvalid   <= 1'b1;
        in_tuser    <= it.func;
        in_tdata    <= {3'b000, it.instr_word, it.reg_value, it.reg_index};
        tx_gap_left = tx_calm ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each completed output transaction and throttles
  // out_tready. A squeeze request stalls the receiver long enough for both
  // pipeline stages to fill so in_tready must drop.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        rx_hold_left = SQUEEZE_CYCLES;
        out_tready <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_hold_left = rx_calm ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: too long without any transaction means the DUT hung.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------

  // Wait for everything in flight to finish so the start address can be
  // rewritten safely. Checked on the falling edge to stay clear of the
  // driver and monitor.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_decodes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_position = v;
  endtask

  initial begin
    for (int k = 0; k < NUM_REGS; k++) pred_regs[k] = '0;

    // Directed part, run from the reset start address.
    push_decode(enc_r(5'd5, 5'd0, 5'd0, {5'd0, FN_JR}));       // table still at reset
    push_load(5'd0, 32'hFFFF_FFFF);                             // entry 0 write dropped
    push_load(5'd31, 32'hFFFF_FFFF);
    push_load(5'd7, 32'h8000_0001);
    push_decode(enc_r(5'd0, 5'd0, 5'd0, {5'd0, FN_JR}));       // jr r0 reads zero
    push_decode(enc_r(5'd31, 5'd0, 5'd0, {5'd0, FN_JALR}));    // writes r0 mask bit
    push_decode(enc_r(5'd7, 5'd0, 5'd31, {5'd0, FN_JALR}));
    push_decode(enc_i(OP_BEQ, 5'd31, 5'd0, 16'h7FFF));
    push_decode(enc_i(OP_BNE, 5'd0, 5'd31, 16'h8000));
    push_decode(enc_i(OP_BLEZ, 5'd1, 5'd9, 16'hFFFF));
    push_decode(enc_i(OP_BGTZ, 5'd2, 5'd0, 16'h0000));
    push_decode(enc_i(OP_REGIMM, 5'd3, RT_BLTZ, 16'h0001));
    push_decode(enc_i(OP_REGIMM, 5'd4, RT_BGEZ, 16'hFFFE));
    push_decode(enc_i(OP_REGIMM, 5'd4, 5'h10, 16'h0010));      // unsupported rt code
    push_decode({OP_J, 26'h3FF_FFFF});
    push_decode({OP_JAL, 26'h000_0000});
    push_decode(enc_r(5'd0, 5'd0, 5'd0, {5'd0, FN_SYSCALL}));
    push_decode(enc_r(5'd31, 5'd30, 5'd29, ALU_LOW_MIN));
    push_decode(enc_r(5'd1, 5'd2, 5'd3, ALU_LOW_MAX));
    push_decode(enc_r(5'd1, 5'd2, 5'd3, ALU_SLTU));
    push_decode(enc_r(5'd1, 5'd2, 5'd3, 11'h0E1));              // shamt set: not ALU
    push_decode(enc_i(OP_ADDI, 5'd31, 5'd0, 16'h0000));
    push_decode(enc_i(OP_LUI, 5'd31, 5'd31, 16'hFFFF));
    push_decode({OP_SPECIAL2, 5'd8, 5'd9, 5'd10, 5'd0, FN_MUL});
    push_decode(enc_i(OP_SW, 5'd29, 5'd31, 16'h8000));
    push_decode(32'hFFFF_FFFF);                                 // undefined opcode
    push_decode(32'h0000_0000);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Random phases, each behind its own start address.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_start(phase_start(p));
      @(negedge clk);
      tx_calm = (p % 3 == 1);
      rx_calm = tx_calm;
      if (p == 2) begin
        // back-to-back offers against a stalled receiver
        tx_calm = 1'b1;
        squeeze_req++;
      end
      repeat (ITEMS_PER_PHASE) pending_items.push_back(random_item());
    end
    wait_drained();

    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
